FILE: hw/rtl/ostef_pkg.sv
// Package: shared types and constants for the overstrike print filter.
package ostef_pkg;

	typedef enum logic [2:0] {
		ESC_IDLE  = 3'd0,
		ESC_AFTER = 3'd1,
		ESC_CTRL  = 3'd2,
		ESC_OTHER = 3'd3,
		ESC_FONT  = 3'd4
	} esc_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EVAL = 2'd1,
		ST_EMIT = 2'd2
	} ctl_state_t;

	localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [1:0] REG_INDENT     = 2'd1;
	localparam logic [1:0] REG_OCR_ONE    = 2'd2;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_UND = 8'h5F;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_EM  = 8'h19;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_P   = 8'h50;
	localparam logic [7:0] CH_F   = 8'h46;
	localparam logic [7:0] CH_LBR = 8'h5B;

	// Output byte plan: a fixed slot order, each slot enabled or not.
	typedef struct packed {
		logic und;       // flushed underscore
		logic ul_off_a;  // ESC [ 0 m before main body
		logic crlf;      // CR LF of a wrap
		logic ind_a;     // indent spaces after wrap
		logic main;      // single main byte (or ESC+c pair)
		logic pair;      // main is ESC followed by main byte
		logic ocr;       // OCR one string instead of main
		logic ul_on;     // DEL ESC [ 4 m
		logic ind_b;     // indent after CR
		logic ul_off_b;  // ESC [ 0 m after char
	} plan_t;

	typedef struct packed {
		logic start;     // begin evaluation of held byte
		logic advance;   // one output transfer done
	} dp_cmd_t;

	typedef struct packed {
		logic busy_emit; // bytes remain to transfer
		logic done;      // plan exhausted
	} dp_sts_t;

	function automatic logic [7:0] ul_off_byte(input logic [1:0] i);
		unique case (i)
			2'd0: ul_off_byte = CH_ESC;
			2'd1: ul_off_byte = CH_LBR;
			2'd2: ul_off_byte = 8'h30;
			default: ul_off_byte = 8'h6D;
		endcase
	endfunction

	function automatic logic [7:0] ul_on_byte(input logic [2:0] i);
		unique case (i)
			3'd0: ul_on_byte = CH_DEL;
			3'd1: ul_on_byte = CH_ESC;
			3'd2: ul_on_byte = CH_LBR;
			3'd3: ul_on_byte = 8'h34;
			default: ul_on_byte = 8'h6D;
		endcase
	endfunction

	function automatic logic [7:0] ocr_byte(input logic [3:0] i);
		unique case (i)
			4'd0: ocr_byte = CH_ESC;
			4'd1: ocr_byte = CH_LBR;
			4'd2: ocr_byte = 8'h31;
			4'd3: ocr_byte = 8'h32;
			4'd4: ocr_byte = 8'h6D;
			4'd5: ocr_byte = CH_ONE;
			4'd6: ocr_byte = CH_ESC;
			4'd7: ocr_byte = CH_LBR;
			4'd8: ocr_byte = 8'h31;
			4'd9: ocr_byte = 8'h31;
			default: ocr_byte = 8'h6D;
		endcase
	endfunction

endpackage

FILE: hw/rtl/ostef_ctrl.sv
// Controller: sequences input transfer, evaluation and byte emission.
module ostef_ctrl import ostef_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_fire,
	input  dp_sts_t sts,
	input  logic    out_free,
	output dp_cmd_t cmd,
	output logic    in_ready,
	output logic    out_load
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_EVAL;
			ST_EVAL: state_d = ST_EMIT;
			ST_EMIT: if (sts.done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EVAL: cmd.start = 1'b1;
			ST_EMIT: begin
				if (sts.busy_emit && out_free) begin
					out_load = 1'b1;
					cmd.advance = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/ostef_dp.sv
// Datapath: filter state, output plan and byte generator.
module ostef_dp import ostef_pkg::*; #(
	parameter int MAX_LINE_WIDTH = 132,
	parameter int TAB_SPACING = 8,
	parameter int MAX_INDENT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_data,
	input  logic       in_fire,
	input  logic [7:0] in_byte,
	input  dp_cmd_t    cmd,
	output dp_sts_t    sts,
	output logic [7:0] cur_byte,
	output logic       cur_last
);

	localparam logic [7:0] MAXW = 8'(MAX_LINE_WIDTH);
	localparam logic [5:0] MAXI = 6'(MAX_INDENT);

	logic [7:0] line_width_q;
	logic [5:0] indent_q;
	logic       ocr_en_q;
	esc_mode_t  mode_q;
	logic [7:0] cprev_q, prev_q, col_q;
	logic       ul_q;
	logic [2:0] ovs_q;
	logic [7:0] c_q;
	plan_t      plan_q;
	logic [3:0] slot_q;
	logic [5:0] sub_q;

	logic [7:0] weff;
	logic [5:0] ieff;
	assign weff = (line_width_q > MAXW) ? MAXW : line_width_q;
	assign ieff = (indent_q > MAXI) ? MAXI : indent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= 8'd80;
			indent_q <= '0;
			ocr_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LINE_WIDTH: line_width_q <= cfg_data;
				REG_INDENT:     indent_q <= cfg_data[5:0];
				REG_OCR_ONE:    ocr_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) c_q <= in_byte;
	end

	// Evaluate one byte: next state and output plan.
	plan_t      p;
	esc_mode_t  mode_n;
	logic [7:0] cprev_n, prev_n, col_n;
	logic       ul_n;
	logic [2:0] ovs_n;
	logic [8:0] tab_t;
	logic       prt;
	logic       em_ul;

	always_comb begin
		p = '0;
		mode_n = mode_q;
		cprev_n = cprev_q;
		prev_n = prev_q;
		col_n = col_q;
		ul_n = ul_q;
		ovs_n = ovs_q;
		prt = 1'b0;
		em_ul = 1'b0;
		tab_t = ({1'b0, col_q} / 9'(TAB_SPACING) + 9'd1) * 9'(TAB_SPACING);
		if (mode_q != ESC_IDLE || c_q == CH_ESC) begin
			if (prev_q == CH_UND) begin
				p.und = 1'b1;
				prev_n = '0;
			end
			if (ul_q) begin
				ul_n = 1'b0;
				ovs_n = '0;
				p.ul_off_a = 1'b1;
			end
			col_n = {2'b0, ieff};
			unique case (mode_q)
				ESC_AFTER: begin
					if (c_q == CH_P) begin
						mode_n = ESC_CTRL;
						cprev_n = c_q;
						p.main = 1'b1;
						p.pair = 1'b1;
					end else if (c_q == CH_F) begin
						mode_n = ESC_FONT;
					end else begin
						mode_n = ESC_OTHER;
						p.main = 1'b1;
						p.pair = 1'b1;
					end
				end
				ESC_CTRL: begin
					if (cprev_q == CH_ESC && c_q == CH_BSL) begin
						mode_n = ESC_IDLE;
						cprev_n = '0;
					end else cprev_n = c_q;
					p.main = 1'b1;
				end
				ESC_OTHER: begin
					if (c_q != CH_P && c_q != CH_LBR && c_q >= 8'h40 && c_q <= 8'h7E)
						mode_n = ESC_IDLE;
					p.main = 1'b1;
				end
				ESC_FONT: if (c_q == CH_BSL) mode_n = ESC_IDLE;
				default: mode_n = ESC_AFTER;
			endcase
		end else begin
			if (prev_q == CH_UND && c_q != CH_BS) begin
				p.und = 1'b1;
				ul_n = 1'b0;
				col_n = (col_q == 8'hFF) ? col_q : col_q + 8'd1;
			end
			unique case (c_q)
				CH_FF, CH_LF: begin
					col_n = '0;
					if (ul_n) begin ul_n = 1'b0; ovs_n = '0; p.ul_off_a = 1'b1; end
					p.main = 1'b1;
				end
				CH_BS: begin
					if (prev_q == CH_UND) begin
						ul_n = 1'b1;
						p.ul_on = 1'b1;
					end else if (ovs_q != 3'd0) begin
						if (ovs_q < 3'd7) ovs_n = ovs_q + 3'd1;
					end else p.main = 1'b1;
				end
				CH_CR: begin
					col_n = {2'b0, ieff};
					if (ul_n) begin ul_n = 1'b0; ovs_n = '0; p.ul_off_a = 1'b1; end
					p.main = 1'b1;
					p.ind_b = 1'b1;
				end
				CH_UND: ;
				CH_TAB: begin
					if (ul_n) begin ul_n = 1'b0; ovs_n = '0; p.ul_off_a = 1'b1; end
					tab_t = ({1'b0, col_n} / 9'(TAB_SPACING) + 9'd1) * 9'(TAB_SPACING);
					col_n = tab_t[8] ? 8'hFF : tab_t[7:0];
					p.main = 1'b1;
				end
				default: begin
					prt = 1'b1;
					if (c_q == CH_EM && ul_n) begin
						ul_n = 1'b0;
						em_ul = 1'b1;
						p.ul_off_a = 1'b1;
					end
				end
			endcase
			if (prt) begin
				if (col_n < weff) begin
					col_n = col_n + 8'd1;
				end else begin
					// wrap: off string, CR LF, indent; an EM close merges into same slot
					if (em_ul) begin
						p.crlf = 1'b1;
					end else begin
						p.ul_off_a = 1'b1;
						p.crlf = 1'b1;
					end
					ul_n = 1'b0;
					col_n = {2'b0, ieff};
					p.ind_a = 1'b1;
				end
				if (ovs_q <= 3'd1) begin
					if (c_q == CH_ONE && weff <= 8'd80 && ocr_en_q) p.ocr = 1'b1;
					else p.main = 1'b1;
				end
				ovs_n = '0;
				if (ul_n) begin
					ul_n = 1'b0;
					p.ul_off_b = 1'b1;
					ovs_n = 3'd1;
				end
			end
			prev_n = c_q;
		end
	end

	// An EM close followed by a wrap emits the off string twice; handle with a flag.
	logic dbl_off_q, dbl_off_n;
	assign dbl_off_n = em_ul && p.crlf;

	// Plan walk: slots 0..8 in order, then slot 9 when done; sub_q counts bytes inside a slot.
	logic       slot_en;
	logic [5:0] slot_len;
	always_comb begin
		slot_en = 1'b0;
		slot_len = 6'd1;
		unique case (slot_q)
			4'd0: begin slot_en = plan_q.und; slot_len = 6'd1; end
			4'd1: begin slot_en = plan_q.ul_off_a; slot_len = dbl_off_q ? 6'd8 : 6'd4; end
			4'd2: begin slot_en = plan_q.crlf; slot_len = 6'd2; end
			4'd3: begin slot_en = plan_q.ind_a && ieff != '0; slot_len = ieff; end
			4'd4: begin slot_en = plan_q.main; slot_len = plan_q.pair ? 6'd2 : 6'd1; end
			4'd5: begin slot_en = plan_q.ocr; slot_len = 6'd11; end
			4'd6: begin slot_en = plan_q.ul_on; slot_len = 6'd5; end
			4'd7: begin slot_en = plan_q.ind_b && ieff != '0; slot_len = ieff; end
			4'd8: begin slot_en = plan_q.ul_off_b; slot_len = 6'd4; end
			default: begin slot_en = 1'b0; slot_len = 6'd1; end
		endcase
	end

	// Last enabled byte: check that no later slot is enabled.
	logic later_en;
	always_comb begin
		later_en = 1'b0;
		for (int k = 0; k < 9; k++) begin
			if (4'(k) > slot_q) begin
				unique case (k)
					0: later_en |= plan_q.und;
					1: later_en |= plan_q.ul_off_a;
					2: later_en |= plan_q.crlf;
					3: later_en |= plan_q.ind_a && ieff != '0;
					4: later_en |= plan_q.main;
					5: later_en |= plan_q.ocr;
					6: later_en |= plan_q.ul_on;
					7: later_en |= plan_q.ind_b && ieff != '0;
					default: later_en |= plan_q.ul_off_b;
				endcase
			end
		end
	end

	always_comb begin
		cur_byte = CH_SP;
		unique case (slot_q)
			4'd0: cur_byte = CH_UND;
			4'd1: cur_byte = ul_off_byte(sub_q[1:0]);
			4'd2: cur_byte = sub_q[0] ? CH_LF : CH_CR;
			4'd4: cur_byte = (plan_q.pair && sub_q == '0) ? CH_ESC : c_q;
			4'd5: cur_byte = ocr_byte(sub_q[3:0]);
			4'd6: cur_byte = ul_on_byte(sub_q[2:0]);
			4'd8: cur_byte = ul_off_byte(sub_q[1:0]);
			default: cur_byte = CH_SP;
		endcase
	end

	assign cur_last = (sub_q == slot_len - 6'd1) && !later_en;
	assign sts.busy_emit = slot_en;
	assign sts.done = (slot_q == 4'd9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ESC_IDLE;
			cprev_q <= '0;
			prev_q <= '0;
			col_q <= '0;
			ul_q <= 1'b0;
			ovs_q <= '0;
			plan_q <= '0;
			slot_q <= 4'd9;
			sub_q <= '0;
			dbl_off_q <= 1'b0;
		end else if (cmd.start) begin
			mode_q <= mode_n;
			cprev_q <= cprev_n;
			prev_q <= prev_n;
			col_q <= col_n;
			ul_q <= ul_n;
			ovs_q <= ovs_n;
			plan_q <= p;
			dbl_off_q <= dbl_off_n;
			slot_q <= '0;
			sub_q <= '0;
		end else if (slot_q != 4'd9) begin
			if (!slot_en) begin
				slot_q <= slot_q + 4'd1;
				sub_q <= '0;
			end else if (cmd.advance) begin
				if (sub_q == slot_len - 6'd1) begin
					slot_q <= slot_q + 4'd1;
					sub_q <= '0;
				end else sub_q <= sub_q + 6'd1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd.start |=> slot_q == 4'd0)
		else $error("plan walk did not restart");
	assert property (@(posedge clk) disable iff (!arst_n) ul_q |-> mode_q == ESC_IDLE)
		else $error("underline open inside escape sequence");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.advance |-> slot_en)
		else $error("transfer from disabled slot");

endmodule

FILE: hw/rtl/overstrike_to_escape_print_filter.sv
// Top level: overstrike-to-escape print filter.
// Takes one text byte per input transfer and sends printer bytes, one per output
// transfer, with last_of_run high on the final byte an input causes; an input
// may cause none. Underscore-backspace-char becomes underline escapes, tabs and
// wraps follow the tracked column, ESC sequences pass through by kind, and a
// digit one may become the OCR one. One input is handled at a time: the
// controller takes it and evaluates it, then the datapath walks nine plan
// slots, skipping each unused slot and sending the bytes of each used one (up
// to 50 on a wrap with full indent), and the controller returns to idle. The
// output register reloads in the cycle its byte transfers, so an unstalled
// printer takes one byte per cycle while a used slot is sent. Configuration
// writes only while idle: the user must keep to this, the block does not enforce it.
module overstrike_to_escape_print_filter import ostef_pkg::*; #(
	parameter int MAX_LINE_WIDTH = 132,
	parameter int TAB_SPACING = 8,
	parameter int MAX_INDENT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic       in_ready, out_load, in_fire, out_free;
	logic [7:0] cur_byte;
	logic       cur_last;

	// accept only while the controller is idle
	assign in_stall = !in_ready;
	assign in_fire  = in_valid && in_ready;
	// output register is free when empty or being drained this cycle
	assign out_free = !out_valid || !out_stall;

	ostef_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .sts, .out_free, .cmd, .in_ready, .out_load
	);

	ostef_dp #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH), .TAB_SPACING(TAB_SPACING), .MAX_INDENT(MAX_INDENT)
	) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .in_fire, .in_byte,
		.cmd, .sts, .cur_byte, .cur_last
	);

	// hold output until transferred, then load the next byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte <= cur_byte;
			last_of_run <= cur_last;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid && out_stall |=> out_valid)
		else $error("stalled output dropped");
	assert property (@(posedge clk) disable iff (!arst_n) in_fire |=> in_stall)
		else $error("second input taken during work");

endmodule
